// ----- src/hlsp_pkg.sv -----
// Shared types, constants and the control store of the hop-limited shortest path block.
`default_nettype none

package hlsp_pkg;

  // Result distance width and its saturation value.
  localparam int unsigned DIST_W = 22;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOP_LIMIT  = 1'b1;
  localparam int unsigned NODE_COUNT_W = 7;
  localparam int unsigned HOP_LIMIT_W  = 8;
  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 7'd64;
  localparam logic [HOP_LIMIT_W-1:0]  HOP_LIMIT_RST  = 8'd64;

  // Request command codes.
  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Step addresses of the control program.
  localparam int unsigned UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t U_CLEAR    = 4'd0;
  localparam upc_t U_IDLE     = 4'd1;
  localparam upc_t U_DISPATCH = 4'd2;
  localparam upc_t U_EDGE_RD  = 4'd3;
  localparam upc_t U_EDGE_WR  = 4'd4;
  localparam upc_t U_QSETUP   = 4'd5;
  localparam upc_t U_INIT     = 4'd6;
  localparam upc_t U_HOPCHK   = 4'd7;
  localparam upc_t U_RELAX    = 4'd8;
  localparam upc_t U_DRAIN0   = 4'd9;
  localparam upc_t U_DRAIN1   = 4'd10;
  localparam upc_t U_WRITE    = 4'd11;
  localparam upc_t U_HOPEND   = 4'd12;
  localparam upc_t U_FINRD    = 4'd13;
  localparam upc_t U_EMIT     = 4'd14;
  localparam upc_t U_RET      = 4'd15;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_TAKE,
    OP_EDGE_RD,
    OP_EDGE_WR,
    OP_QSETUP,
    OP_INIT,
    OP_HOPSTART,
    OP_RELAX,
    OP_WRITE,
    OP_HOPEND,
    OP_FINRD,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_CLR_MORE,
    C_NO_REQ,
    C_IS_QUERY,
    C_OUT_OF_RANGE,
    C_J_MORE,
    C_V_MORE,
    C_HOPS_DONE,
    C_OUT_BLOCKED
  } cond_e;

  // One control word: datapath action, jump condition and jump target.
  // When the condition fails the sequencer steps to the next address.
  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  target;
  } ctrl_word_t;

  function automatic ctrl_word_t mk(input op_e op, input cond_e cond, input upc_t target);
    ctrl_word_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic ctrl_word_t ucode(input upc_t upc);
    ctrl_word_t w;
    case (upc)
      U_CLEAR:    w = mk(OP_CLEAR,    C_CLR_MORE,     U_CLEAR);
      U_IDLE:     w = mk(OP_TAKE,     C_NO_REQ,       U_IDLE);
      U_DISPATCH: w = mk(OP_NOP,      C_IS_QUERY,     U_QSETUP);
      U_EDGE_RD:  w = mk(OP_EDGE_RD,  C_NEVER,        U_IDLE);
      U_EDGE_WR:  w = mk(OP_EDGE_WR,  C_ALWAYS,       U_IDLE);
      U_QSETUP:   w = mk(OP_QSETUP,   C_OUT_OF_RANGE, U_EMIT);
      U_INIT:     w = mk(OP_INIT,     C_J_MORE,       U_INIT);
      U_HOPCHK:   w = mk(OP_HOPSTART, C_HOPS_DONE,    U_FINRD);
      U_RELAX:    w = mk(OP_RELAX,    C_V_MORE,       U_RELAX);
      U_DRAIN0:   w = mk(OP_NOP,      C_NEVER,        U_IDLE);
      U_DRAIN1:   w = mk(OP_NOP,      C_NEVER,        U_IDLE);
      U_WRITE:    w = mk(OP_WRITE,    C_J_MORE,       U_RELAX);
      U_HOPEND:   w = mk(OP_HOPEND,   C_ALWAYS,       U_HOPCHK);
      U_FINRD:    w = mk(OP_FINRD,    C_NEVER,        U_IDLE);
      U_EMIT:     w = mk(OP_EMIT,     C_OUT_BLOCKED,  U_EMIT);
      U_RET:      w = mk(OP_NOP,      C_ALWAYS,       U_IDLE);
      default:    w = mk(OP_NOP,      C_ALWAYS,       U_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- src/hlsp_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module hlsp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/hop_limited_shortest_path.sv -----
// Top level of the hop-limited shortest path block: control sequencer, datapath and stores.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
// in        in         in_valid_i / in_ready_o   cmd_i, src_node_i, dst_node_i, weight_i
// out       out        out_valid_o / out_ready_i reachable_o, distance_o
//
// After reset the edge store is swept one entry a cycle, all MAX_NODES * 2**clog2(MAX_NODES)
// entries (4096 at the defaults), before the first request is taken.
// An edge request passes the dispatch, edge read and edge write steps. A query with n effective nodes fills
// a distance row, then per hop relaxes each node over all n nodes; the inner loop reads one edge-store word a cycle.
// A query result waits in the output register; the next request is taken meanwhile, and
// the sequencer only holds when a new result meets a still-full output register.

module hop_limited_shortest_path #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [hlsp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [hlsp_pkg::HOP_LIMIT_W-1:0]    cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                cmd_i,
  input  wire logic [5:0]                          src_node_i,
  input  wire logic [5:0]                          dst_node_i,
  input  wire logic [15:0]                         weight_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     reachable_o,
  output logic [hlsp_pkg::DIST_W-1:0]              distance_o
);

  localparam int NB         = $clog2(MAX_NODES);
  localparam int EAW        = 2 * NB;
  localparam int EDGE_DEPTH = MAX_NODES * (2 ** NB);
  localparam int DAW        = NB + 1;
  localparam int DIST_DEPTH = 2 * (2 ** NB);
  localparam int EW         = WEIGHT_BITS + 1;
  localparam int DW         = hlsp_pkg::DIST_W;
  localparam int NCW        = $clog2(MAX_NODES + 1);
  localparam int CW         = (NCW > 8) ? NCW : 8;
  localparam int SW         = ((WEIGHT_BITS > DW) ? WEIGHT_BITS : DW) + 1;
  localparam int WW         = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;

  // Sequencer
  hlsp_pkg::upc_t       upc_q, upc_d;
  hlsp_pkg::ctrl_word_t ctrl;
  logic                 jump;

  // Configuration
  logic [hlsp_pkg::NODE_COUNT_W-1:0] node_count_q;
  logic [hlsp_pkg::HOP_LIMIT_W-1:0]  hop_limit_q;

  // Latched request and loop state
  logic                   cmd_q;
  logic [NB-1:0]          src_q, dst_q;
  logic [WEIGHT_BITS-1:0] wgt_q;
  logic                   ok_q;
  logic [NB-1:0]          last_q;
  logic [NCW-1:0]         hops_left_q;
  logic                   cur_q;
  logic [NB-1:0]          j_q, v_q;
  logic [EAW-1:0]         clr_q;

  // Relaxation pipeline
  logic          rv1_q, rv2_q;
  logic [DW-1:0] cand_q, best_q;
  logic          cand_ok_q, best_ok_q;
  logic [SW-1:0] sum;
  logic [DW-1:0] sum_sat;

  // Output register
  logic          out_valid_q, reach_q;
  logic [DW-1:0] dist_q;
  logic          out_blocked;

  // Memory ports
  logic           e_we, e_re;
  logic [EAW-1:0] e_waddr, e_raddr;
  logic [EW-1:0]  e_wdata, e_rdata;
  logic           d_we, d_re;
  logic [DAW-1:0] d_waddr, d_raddr;
  logic [DW:0]    d_wdata, d_rdata;

  // Request decode
  logic [CW-1:0]          src_ext, dst_ext, nc_ext, hop_ext, n_eff, n_eff_m1, hops_c;
  logic [WW-1:0]          weight_ext;
  logic                   edge_ok, query_ok;
  logic                   in_accept;

  assign ctrl        = hlsp_pkg::ucode(upc_q);
  assign out_blocked = out_valid_q && !out_ready_i;
  assign in_ready_o  = (ctrl.op == hlsp_pkg::OP_TAKE);
  assign in_accept   = in_valid_i && in_ready_o;

  always_comb begin
    case (ctrl.cond)
      hlsp_pkg::C_NEVER:        jump = 1'b0;
      hlsp_pkg::C_ALWAYS:       jump = 1'b1;
      hlsp_pkg::C_CLR_MORE:     jump = (clr_q != EAW'(EDGE_DEPTH - 1));
      hlsp_pkg::C_NO_REQ:       jump = !in_valid_i;
      hlsp_pkg::C_IS_QUERY:     jump = (cmd_q == hlsp_pkg::CMD_QUERY);
      hlsp_pkg::C_OUT_OF_RANGE: jump = !ok_q;
      hlsp_pkg::C_J_MORE:       jump = (j_q != last_q);
      hlsp_pkg::C_V_MORE:       jump = (v_q != last_q);
      hlsp_pkg::C_HOPS_DONE:    jump = (hops_left_q == '0);
      hlsp_pkg::C_OUT_BLOCKED:  jump = out_blocked;
      default:                  jump = 1'b1;
    endcase
    upc_d = jump ? ctrl.target : upc_q + hlsp_pkg::upc_t'(1);
  end

  // Effective node count is clamped to 1 .. MAX_NODES; the hop count to n_eff.
  always_comb begin
    src_ext    = CW'(src_node_i);
    dst_ext    = CW'(dst_node_i);
    nc_ext     = CW'(node_count_q);
    hop_ext    = CW'(hop_limit_q);
    weight_ext = WW'(weight_i);
    if (nc_ext == '0) begin
      n_eff = CW'(1);
    end else if (nc_ext > CW'(MAX_NODES)) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = nc_ext;
    end
    n_eff_m1 = n_eff - CW'(1);
    hops_c   = (hop_ext < n_eff) ? hop_ext : n_eff;
    edge_ok  = (src_ext < CW'(MAX_NODES)) && (dst_ext < CW'(MAX_NODES));
    query_ok = (src_ext < n_eff) && (dst_ext < n_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q        <= hlsp_pkg::U_CLEAR;
      node_count_q <= hlsp_pkg::NODE_COUNT_RST;
      hop_limit_q  <= hlsp_pkg::HOP_LIMIT_RST;
      clr_q        <= '0;
      cmd_q        <= hlsp_pkg::CMD_EDGE;
      ok_q         <= 1'b0;
      last_q       <= '0;
      hops_left_q  <= '0;
      cur_q        <= 1'b0;
      j_q          <= '0;
      v_q          <= '0;
      rv1_q        <= 1'b0;
      rv2_q        <= 1'b0;
      best_ok_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      upc_q <= upc_d;
      rv1_q <= (ctrl.op == hlsp_pkg::OP_RELAX);
      rv2_q <= rv1_q;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          hlsp_pkg::CFG_NODE_COUNT: node_count_q <= cfg_wdata_i[hlsp_pkg::NODE_COUNT_W-1:0];
          hlsp_pkg::CFG_HOP_LIMIT:  hop_limit_q  <= cfg_wdata_i;
          default: ;
        endcase
      end

      case (ctrl.op)
        hlsp_pkg::OP_CLEAR: begin
          clr_q <= clr_q + EAW'(1);
        end
        hlsp_pkg::OP_TAKE: begin
          if (in_accept) begin
            cmd_q  <= cmd_i;
            ok_q   <= (cmd_i == hlsp_pkg::CMD_QUERY) ? query_ok : edge_ok;
            last_q <= n_eff_m1[NB-1:0];
          end
        end
        hlsp_pkg::OP_QSETUP: begin
          hops_left_q <= hops_c[NCW-1:0];
          cur_q       <= 1'b0;
          j_q         <= '0;
        end
        hlsp_pkg::OP_INIT: begin
          j_q <= j_q + NB'(1);
        end
        hlsp_pkg::OP_HOPSTART: begin
          j_q       <= '0;
          v_q       <= '0;
          best_ok_q <= 1'b0;
        end
        hlsp_pkg::OP_RELAX: begin
          v_q <= v_q + NB'(1);
        end
        hlsp_pkg::OP_WRITE: begin
          j_q       <= j_q + NB'(1);
          v_q       <= '0;
          best_ok_q <= 1'b0;
        end
        hlsp_pkg::OP_HOPEND: begin
          cur_q       <= ~cur_q;
          hops_left_q <= hops_left_q - NCW'(1);
        end
        default: ;
      endcase

      // The last candidate of a column passes the drain steps, so it is in the best register by its write step.
      if (rv2_q && cand_ok_q && (!best_ok_q || (cand_q < best_q))) begin
        best_ok_q <= 1'b1;
      end

      if ((ctrl.op == hlsp_pkg::OP_EMIT) && !out_blocked) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      src_q <= src_ext[NB-1:0];
      dst_q <= dst_ext[NB-1:0];
      wgt_q <= weight_ext[WEIGHT_BITS-1:0];
    end
    if (rv1_q) begin
      cand_q    <= sum_sat;
      cand_ok_q <= d_rdata[DW] && !e_rdata[WEIGHT_BITS];
    end
    if (rv2_q && cand_ok_q && (!best_ok_q || (cand_q < best_q))) begin
      best_q <= cand_q;
    end
    if ((ctrl.op == hlsp_pkg::OP_EMIT) && !out_blocked) begin
      reach_q <= ok_q && d_rdata[DW];
      dist_q  <= (ok_q && d_rdata[DW]) ? d_rdata[DW-1:0] : '0;
    end
  end

  // Saturating the running sums keeps the final minimum exact after saturation.
  always_comb begin
    sum     = SW'(d_rdata[DW-1:0]) + SW'(e_rdata[WEIGHT_BITS-1:0]);
    sum_sat = (sum > SW'(hlsp_pkg::DIST_MAX)) ? hlsp_pkg::DIST_MAX : sum[DW-1:0];
  end

  // Edge store: entry {from, to}, top bit set means no edge.
  always_comb begin
    e_we    = 1'b0;
    e_waddr = {src_q, dst_q};
    e_wdata = {1'b0, wgt_q};
    e_re    = 1'b0;
    e_raddr = {src_q, dst_q};
    case (ctrl.op)
      hlsp_pkg::OP_CLEAR: begin
        e_we    = 1'b1;
        e_waddr = clr_q;
        e_wdata = (clr_q[EAW-1:NB] == clr_q[NB-1:0]) ? '0 : {1'b1, {WEIGHT_BITS{1'b0}}};
      end
      hlsp_pkg::OP_EDGE_RD: begin
        e_re = 1'b1;
      end
      hlsp_pkg::OP_EDGE_WR: begin
        e_we = ok_q && ({1'b0, wgt_q} < e_rdata);
      end
      hlsp_pkg::OP_RELAX: begin
        e_re    = 1'b1;
        e_raddr = {v_q, j_q};
      end
      default: ;
    endcase
  end

  // Distance rows: entry {row, node}, top bit is the reached flag.
  always_comb begin
    d_we    = 1'b0;
    d_waddr = {cur_q, j_q};
    d_wdata = {(j_q == src_q), {DW{1'b0}}};
    d_re    = 1'b0;
    d_raddr = {cur_q, v_q};
    case (ctrl.op)
      hlsp_pkg::OP_INIT: begin
        d_we = 1'b1;
      end
      hlsp_pkg::OP_WRITE: begin
        d_we    = 1'b1;
        d_waddr = {~cur_q, j_q};
        d_wdata = {best_ok_q, best_q};
      end
      hlsp_pkg::OP_RELAX: begin
        d_re = 1'b1;
      end
      hlsp_pkg::OP_FINRD: begin
        d_re    = 1'b1;
        d_raddr = {cur_q, dst_q};
      end
      default: ;
    endcase
  end

  hlsp_ram #(
    .WIDTH  (EW),
    .DEPTH  (EDGE_DEPTH),
    .ADDR_W (EAW)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .re_i    (e_re),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  hlsp_ram #(
    .WIDTH  (DW + 1),
    .DEPTH  (DIST_DEPTH),
    .ADDR_W (DAW)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .re_i    (d_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign reachable_o = reach_q;
  assign distance_o  = dist_q;

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.op == hlsp_pkg::OP_EMIT))
    else $error("result appeared outside the emit step");

  a_relax_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == hlsp_pkg::OP_RELAX) |-> ((v_q <= last_q) && (j_q <= last_q)))
    else $error("relaxation indexes beyond the node count");

  a_hop_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == hlsp_pkg::OP_HOPEND) |-> (hops_left_q != '0))
    else $error("hop counter underflow");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (upc_q == hlsp_pkg::U_DISPATCH))
    else $error("accepted request not dispatched");

endmodule

`default_nettype wire
